// ===== rtl/hid_keyboard_report_diff_assert.svh =====
// Assertion macros shared by the checker of the keyboard report decoder.
`ifndef HID_KEYBOARD_REPORT_DIFF_ASSERT_SVH
`define HID_KEYBOARD_REPORT_DIFF_ASSERT_SVH

// Clocked assertion. The assertion is off while reset is applied.
`define HKRD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A result beat that waits to be taken keeps the given port steady.
`define HKRD_ASSERT_HOLD(lbl, sig) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (!empty && !pop) |=> $stable(sig)) else $error("result beat changed while stalled");

`endif

// ===== rtl/hkrd_pkg.sv =====
// Shared types, constants and helpers of the keyboard report decoder.
package hkrd_pkg;

    localparam int KEY_W         = 8;
    localparam int REPORT_SLOTS  = 6;
    localparam int EVENT_SLOTS   = 2 * REPORT_SLOTS;
    localparam int SEL_W         = $clog2(EVENT_SLOTS);
    localparam int KEYCODE_SPACE = 256;
    localparam int MAP_W         = KEY_W + 1;

    localparam int KEY_SLOTS_DEFAULT   = 6;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [KEY_W-1:0] CODE_EMPTY    = 8'h00;
    localparam logic [KEY_W-1:0] CODE_ROLLOVER = 8'h01;

    localparam int LSHIFT_IDX = 1;
    localparam int RSHIFT_IDX = 5;

    // One classified report: press candidates in slots 0..5, releases in 6..11.
    typedef struct packed {
        logic                              shift;
        logic [EVENT_SLOTS-1:0]            mask;
        logic [EVENT_SLOTS-1:0][KEY_W-1:0] keys;
    } report_work_t;

    typedef struct packed {
        logic [KEY_W-1:0] keycode;
        logic             press;
        logic             shift;
        logic             last;
    } key_event_t;

    function automatic logic key_in_map(input logic [KEY_W-1:0] code);
        return {1'b0, code} < MAP_W'(KEYCODE_SPACE);
    endfunction

endpackage

// ===== rtl/hkrd_front.sv =====
// Front end: takes a report, works out press and release events, keeps the key list.
module hkrd_front
    import hkrd_pkg::*;
#(
    parameter int USED_SLOTS = KEY_SLOTS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  logic [KEY_W-1:0]                   modifier_bits,
    input  logic [REPORT_SLOTS-1:0][KEY_W-1:0] slots,
    output logic                               q_push,
    output report_work_t                       q_data
);

    logic [KEY_W-1:0]        prev_reg  [USED_SLOTS];
    logic [KEY_W-1:0]        prev_next [USED_SLOTS];
    logic [REPORT_SLOTS-1:0] cur_valid;
    logic [KEY_W-1:0]        cur_key   [REPORT_SLOTS];
    logic [USED_SLOTS-1:0]   prev_valid;
    logic                    rollover;
    logic                    run_cur;
    logic                    run_prev;

    always_comb
    begin
        rollover = (slots[0] == CODE_ROLLOVER);
        run_cur  = 1'b1;
        run_prev = 1'b1;
        for (int i = 0; i < REPORT_SLOTS; i++)
        begin
            cur_valid[i] = 1'b0;
            cur_key[i]   = '0;
            if (i < USED_SLOTS)
            begin
                run_cur      = run_cur && (slots[i] != CODE_EMPTY) &&
                               (slots[i] != CODE_ROLLOVER);
                cur_valid[i] = run_cur;
                cur_key[i]   = run_cur ? slots[i] : '0;
            end
        end
        for (int i = 0; i < USED_SLOTS; i++)
        begin
            run_prev      = run_prev && (prev_reg[i] != CODE_EMPTY) &&
                            (prev_reg[i] != CODE_ROLLOVER);
            prev_valid[i] = run_prev;
            prev_next[i]  = cur_key[i];
        end
    end

    // A key is held exactly when it sits in the stored list, so the pressed map
    // reduces to list membership checks.
    always_comb
    begin
        logic hit;
        logic dup;
        q_data       = '0;
        q_data.shift = modifier_bits[LSHIFT_IDX] | modifier_bits[RSHIFT_IDX];
        for (int i = 0; i < USED_SLOTS; i++)
        begin
            hit = 1'b0;
            dup = 1'b0;
            for (int j = 0; j < USED_SLOTS; j++)
                hit = hit | (prev_valid[j] && (prev_reg[j] == cur_key[i]));
            for (int j = 0; j < i; j++)
                dup = dup | (cur_valid[j] && (cur_key[j] == cur_key[i]));
            q_data.keys[i] = cur_key[i];
            q_data.mask[i] = cur_valid[i] && key_in_map(cur_key[i]) && !hit && !dup;
        end
        for (int i = 0; i < USED_SLOTS; i++)
        begin
            hit = 1'b0;
            dup = 1'b0;
            for (int j = 0; j < USED_SLOTS; j++)
                hit = hit | (cur_valid[j] && (cur_key[j] == prev_reg[i]));
            for (int j = 0; j < i; j++)
                dup = dup | (prev_reg[j] == prev_reg[i]);
            q_data.keys[REPORT_SLOTS + i] = prev_reg[i];
            q_data.mask[REPORT_SLOTS + i] = prev_valid[i] && key_in_map(prev_reg[i]) &&
                                            !hit && !dup;
        end
        q_push = accept && !rollover && (q_data.mask != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < USED_SLOTS; i++)
                prev_reg[i] <= '0;
        end
        else if (accept && !rollover)
        begin
            for (int i = 0; i < USED_SLOTS; i++)
                prev_reg[i] <= prev_next[i];
        end
    end

endmodule

// ===== rtl/hkrd_queue.sv =====
// Short queue of classified reports between front and back end.
module hkrd_queue
    import hkrd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  report_work_t push_data,
    output logic         full,
    input  logic         pop,
    output report_work_t head,
    output logic         empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    report_work_t     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/hkrd_back.sv =====
// Back end: walks a classified report and sends one event per beat.
module hkrd_back
    import hkrd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  report_work_t q_head,
    input  logic         q_empty,
    output logic         q_pop,
    input  logic         pop,
    output logic         empty,
    output key_event_t   result
);

    report_work_t           work_reg;
    report_work_t           work_next;
    logic                   busy_reg;
    logic                   busy_next;
    key_event_t             out_reg;
    key_event_t             out_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [SEL_W-1:0]       sel;
    logic [EVENT_SLOTS-1:0] rest;
    logic                   out_adv;
    logic                   emit;
    logic                   done;

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    always_comb
    begin
        sel = '0;
        for (int i = EVENT_SLOTS - 1; i >= 0; i--)
        begin
            if (work_reg.mask[i])
                sel = SEL_W'(i);
        end
        rest    = work_reg.mask & ~(EVENT_SLOTS'(1) << sel);
        out_adv = !out_valid_reg || pop;
        emit    = busy_reg && out_adv;
        done    = emit && (rest == '0);
        q_pop   = !q_empty && (!busy_reg || done);

        busy_next      = busy_reg;
        work_next      = work_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_adv)
            out_valid_next = busy_reg;
        if (emit)
        begin
            out_next.keycode = work_reg.keys[sel];
            out_next.press   = (sel < SEL_W'(REPORT_SLOTS));
            out_next.shift   = work_reg.shift;
            out_next.last    = (rest == '0);
            work_next.mask   = rest;
            if (done)
                busy_next = 1'b0;
        end
        if (q_pop)
        begin
            work_next = q_head;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        out_reg  <= out_next;
    end

endmodule

// ===== rtl/hid_keyboard_report_diff.sv =====
// Top level of the boot-keyboard report decoder: turns reports into key events.
//
// Each input beat is one boot-keyboard report (modifier byte and six keycode
// slots); each result beat is one key event. The front end takes a report
// whenever the report queue has room, compares it with the stored key list,
// and stores the new list at once, so reports may arrive on back to back
// cycles. A report whose first slot is the rollover code is taken but
// gives no events and leaves the stored list alone; a report that changes
// nothing gives no events either. Presses come first in slot order, then
// releases in the order of the previous list; last_event marks the final
// event of a report and shift_held repeats the report's shift state on every
// event. The back end sends one event per cycle while the output register is
// free or being popped, and it loads the next report from the queue as it
// sends the last event of the current one; a report gives at most twelve
// events. The queue between the two parts holds QUEUE_DEPTH classified
// reports, and the output register lets the front keep taking reports
// while a result waits to be popped.
module hid_keyboard_report_diff
    import hkrd_pkg::*;
#(
    parameter int KEY_SLOTS   = KEY_SLOTS_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [KEY_W-1:0] modifier_bits,
    input  logic [KEY_W-1:0] key_slot_0,
    input  logic [KEY_W-1:0] key_slot_1,
    input  logic [KEY_W-1:0] key_slot_2,
    input  logic [KEY_W-1:0] key_slot_3,
    input  logic [KEY_W-1:0] key_slot_4,
    input  logic [KEY_W-1:0] key_slot_5,
    output logic             empty,
    input  logic             pop,
    output logic [KEY_W-1:0] event_keycode,
    output logic             is_press,
    output logic             shift_held,
    output logic             last_event
);

    // Only the first KEY_SLOTS slots are read, at least one and at most six.
    localparam int USED_SLOTS = (KEY_SLOTS < 1) ? 1 :
                                ((KEY_SLOTS > REPORT_SLOTS) ? REPORT_SLOTS : KEY_SLOTS);

    logic [REPORT_SLOTS-1:0][KEY_W-1:0] slots;
    logic                               accept;
    logic                               q_push;
    report_work_t                       q_in;
    report_work_t                       q_head;
    logic                               q_empty;
    logic                               q_pop;
    key_event_t                         result;

    assign slots  = {key_slot_5, key_slot_4, key_slot_3, key_slot_2, key_slot_1, key_slot_0};
    // Take a report beat whenever the queue has room for its events.
    assign accept = push && !full;

    hkrd_front #(
        .USED_SLOTS (USED_SLOTS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .modifier_bits (modifier_bits),
        .slots         (slots),
        .q_push        (q_push),
        .q_data        (q_in)
    );

    hkrd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    hkrd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_head  (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

    assign event_keycode = result.keycode;
    assign is_press      = result.press;
    assign shift_held    = result.shift;
    assign last_event    = result.last;

endmodule

// ===== rtl/hkrd_checker.sv =====
// Port-level checker of the keyboard report decoder, bound to the top level.
`include "hid_keyboard_report_diff_assert.svh"

module hkrd_checker
    import hkrd_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             empty,
    input logic             pop,
    input logic [KEY_W-1:0] event_keycode,
    input logic             is_press,
    input logic             shift_held,
    input logic             last_event
);

    `HKRD_ASSERT_HOLD(a_hold_keycode, event_keycode)
    `HKRD_ASSERT(a_report_no_gap, (!empty && pop && !last_event) |=> !empty, "events of one report have a gap")
    `HKRD_ASSERT(a_report_shift, (!empty && pop && !last_event) |=> (shift_held == $past(shift_held)), "shift changed inside a report")
    `HKRD_ASSERT(a_press_first, (!empty && pop && !last_event && !is_press) |=> !is_press, "press after release inside a report")
    `HKRD_ASSERT(a_code_listed, !empty |-> (event_keycode != CODE_EMPTY && event_keycode != CODE_ROLLOVER), "event carries an empty or rollover code")

endmodule

bind hid_keyboard_report_diff hkrd_checker u_checker (.*);
